>>> rtl/vfd_pkg.sv
// vfd_pkg: shared types and constants of the variable-length frame deframer
// holds result codes, parser phase encoding, result struct and csr map
// no dependencies

package vfd_pkg;

   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned TypeWidth    = 4;
   localparam int unsigned KindWidth    = 3;
   localparam int unsigned LenWidth     = 28;
   localparam int unsigned GroupBits    = 7;
   // wide enough for the accumulated length plus one shifted group
   localparam int unsigned LenSumWidth  = LenWidth + GroupBits + 1;
   localparam int unsigned ShiftWidth   = 6;
   localparam int unsigned MaskWidth    = 16;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned CsrAddrWidth = 1;

   localparam logic [LenWidth-1:0]     LenMax          = '1;
   localparam logic [MaskWidth-1:0]    TypeMaskReset   = 16'hE004;
   localparam logic [CsrAddrWidth-1:0] AddrAllowedMask = 1'b0;

   typedef enum logic [KindWidth-1:0] {
      KIND_HEAD     = 3'd0,
      KIND_DATA     = 3'd1,
      KIND_EMPTY    = 3'd2,
      KIND_BADTYPE  = 3'd3,
      KIND_OVERFLOW = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_LEN  = 3'b010,
      PH_PAY  = 3'b100
   } phase_type;

   typedef struct packed {
      kind_type                kind;
      logic [TypeWidth-1:0]    msg_type;
      logic [ByteWidth-1:0]    data_byte;
      logic                    frame_last;
      logic [LenWidth-1:0]     frame_length;
      logic                    chunk_done;
   } result_type;

endpackage

>>> rtl/vfd_req_if.sv
// vfd_req_if: byte input channel of the deframer, valid/ready handshake
// depends on vfd_pkg for field widths

interface vfd_req_if;
   logic                             valid;
   logic                             ready;
   logic [vfd_pkg::ByteWidth-1:0]    rx_byte;
   logic                             chunk_end;

   modport source (output valid, output rx_byte, output chunk_end, input ready);
   modport sink   (input valid, input rx_byte, input chunk_end, output ready);
endinterface

>>> rtl/vfd_rsp_if.sv
// vfd_rsp_if: result channel of the deframer, valid/ready handshake
// depends on vfd_pkg for field widths

interface vfd_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [vfd_pkg::KindWidth-1:0]    kind;
   logic [vfd_pkg::TypeWidth-1:0]    msg_type;
   logic [vfd_pkg::ByteWidth-1:0]    data_byte;
   logic                             frame_last;
   logic [vfd_pkg::LenWidth-1:0]     frame_length;
   logic                             chunk_done;

   modport source (output valid, output kind, output msg_type, output data_byte,
                   output frame_last, output frame_length, output chunk_done,
                   input ready);
   modport sink   (input valid, input kind, input msg_type, input data_byte,
                   input frame_last, input frame_length, input chunk_done,
                   output ready);
endinterface

>>> rtl/vfd_csr.sv
// vfd_csr: apb-style register block holding the allowed message type mask
// depends on vfd_pkg for the register map and reset value

module vfd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [vfd_pkg::CsrAddrWidth-1:0]    paddr,
   input  logic [vfd_pkg::CsrDataWidth-1:0]    pwdata,
   output logic [vfd_pkg::CsrDataWidth-1:0]    prdata,
   output logic                                pready,
   output logic [vfd_pkg::MaskWidth-1:0]       type_mask
);

   logic [vfd_pkg::MaskWidth-1:0] mask_ff;
   logic [vfd_pkg::MaskWidth-1:0] mask_in;
   logic                          wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr == vfd_pkg::AddrAllowedMask);

   always_comb begin
      mask_in = mask_ff;
      if (wr_hit) begin
         mask_in = pwdata[vfd_pkg::MaskWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= vfd_pkg::TypeMaskReset;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_comb begin
      prdata = '0;
      unique case (paddr)
         vfd_pkg::AddrAllowedMask: begin
            prdata = {{(vfd_pkg::CsrDataWidth-vfd_pkg::MaskWidth){1'b0}}, mask_ff};
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign type_mask = mask_ff;

endmodule

>>> rtl/vfd_parser.sv
// vfd_parser: frame parser state and the per-byte next-state/result logic
// depends on vfd_pkg for phase encoding, result codes and the result struct

module vfd_parser #(
   parameter int unsigned MAX_LEN_GROUPS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              take,
   input  logic [vfd_pkg::ByteWidth-1:0]     rx_byte,
   input  logic                              chunk_end,
   input  logic [vfd_pkg::MaskWidth-1:0]     type_mask,
   output vfd_pkg::result_type               result
);

   localparam int unsigned GroupIdxWidth = (MAX_LEN_GROUPS > 1) ? $clog2(MAX_LEN_GROUPS) : 1;
   localparam logic [GroupIdxWidth-1:0] LastGroup = GroupIdxWidth'(MAX_LEN_GROUPS - 1);

   vfd_pkg::phase_type                 phase_ff,  phase_in;
   logic [vfd_pkg::TypeWidth-1:0]      type_ff,   type_in;
   logic [vfd_pkg::LenWidth-1:0]       accum_ff,  accum_in;
   logic [GroupIdxWidth-1:0]           gidx_ff,   gidx_in;
   logic [vfd_pkg::LenWidth-1:0]       count_ff,  count_in;

   logic [vfd_pkg::ShiftWidth-1:0]     shamt;
   logic [vfd_pkg::LenSumWidth-1:0]    len_sum;
   logic [vfd_pkg::LenWidth-1:0]       len_sat;
   logic [vfd_pkg::LenWidth-1:0]       count_inc;
   logic [vfd_pkg::TypeWidth-1:0]      hdr_type;

   // length group arithmetic: add the next 7-bit group at its place, saturate
   assign shamt    = vfd_pkg::ShiftWidth'(gidx_ff * vfd_pkg::GroupBits);
   assign len_sum  = vfd_pkg::LenSumWidth'(accum_ff)
                   + (vfd_pkg::LenSumWidth'(rx_byte[vfd_pkg::GroupBits-1:0]) << shamt);
   assign len_sat  = (len_sum > vfd_pkg::LenSumWidth'(vfd_pkg::LenMax))
                   ? vfd_pkg::LenMax : len_sum[vfd_pkg::LenWidth-1:0];
   assign count_inc = count_ff + 1'b1;
   assign hdr_type  = rx_byte[vfd_pkg::ByteWidth-1:vfd_pkg::ByteWidth-vfd_pkg::TypeWidth];

   always_comb begin
      phase_in = phase_ff;
      type_in  = type_ff;
      accum_in = accum_ff;
      gidx_in  = gidx_ff;
      count_in = count_ff;

      result.kind         = vfd_pkg::KIND_HEAD;
      result.msg_type     = type_ff;
      result.data_byte    = '0;
      result.frame_last   = 1'b0;
      result.frame_length = accum_ff;
      result.chunk_done   = chunk_end;

      unique case (phase_ff)
         vfd_pkg::PH_LEN: begin
            result.frame_length = len_sat;
            accum_in            = len_sat;
            if (rx_byte[vfd_pkg::ByteWidth-1]) begin
               if (gidx_ff == LastGroup) begin
                  // continuation past the last allowed group
                  result.kind = vfd_pkg::KIND_OVERFLOW;
                  phase_in    = vfd_pkg::PH_IDLE;
                  type_in     = '0;
                  accum_in    = '0;
                  gidx_in     = '0;
                  count_in    = '0;
               end else begin
                  gidx_in = gidx_ff + 1'b1;
               end
            end else if (len_sat == '0) begin
               result.kind       = vfd_pkg::KIND_EMPTY;
               result.frame_last = 1'b1;
               phase_in          = vfd_pkg::PH_IDLE;
               type_in           = '0;
               accum_in          = '0;
               gidx_in           = '0;
               count_in          = '0;
            end else begin
               phase_in = vfd_pkg::PH_PAY;
               count_in = '0;
            end
         end
         vfd_pkg::PH_PAY: begin
            result.kind      = vfd_pkg::KIND_DATA;
            result.data_byte = rx_byte;
            count_in         = count_inc;
            if (count_inc >= accum_ff) begin
               result.frame_last = 1'b1;
               phase_in          = vfd_pkg::PH_IDLE;
               type_in           = '0;
               accum_in          = '0;
               gidx_in           = '0;
               count_in          = '0;
            end
         end
         default: begin
            // header byte; unused phase codes behave as idle
            result.msg_type     = hdr_type;
            result.frame_length = '0;
            accum_in            = '0;
            gidx_in             = '0;
            count_in            = '0;
            if (type_mask[hdr_type]) begin
               phase_in = vfd_pkg::PH_LEN;
               type_in  = hdr_type;
            end else begin
               result.kind = vfd_pkg::KIND_BADTYPE;
               phase_in    = vfd_pkg::PH_IDLE;
               type_in     = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= vfd_pkg::PH_IDLE;
         type_ff  <= '0;
         accum_ff <= '0;
         gidx_ff  <= '0;
         count_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         accum_ff <= accum_in;
         gidx_ff  <= gidx_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/vfd_out_stage.sv
// vfd_out_stage: result register with valid, decoupling the parser from the sink
// depends on vfd_pkg for the result struct

module vfd_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  vfd_pkg::result_type   result_in,
   input  logic                  sink_ready,
   output logic                  out_valid,
   output logic                  can_load,
   output vfd_pkg::result_type   result_out
);

   logic                 valid_ff;
   logic                 valid_in;
   vfd_pkg::result_type  data_ff;

   // a new result may enter when the register is empty or drains this cycle
   assign can_load = !valid_ff || sink_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (sink_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign result_out = data_ff;

endmodule

>>> rtl/varlen_frame_deframer_core.sv
// varlen_frame_deframer_core: top level of the byte-serial frame deframer
// depends on vfd_pkg, vfd_req_if, vfd_rsp_if, vfd_csr, vfd_parser, vfd_out_stage

// Parses a received byte stream one byte per transfer into frames made of a
// header byte (message type in the top nibble, checked against the
// allowed_type_mask register), a length sent as 7-bit groups least
// significant first with bit 7 marking a following group, and that many
// payload bytes. Every input transfer yields exactly one result transfer:
// header/length bytes report kind 0, payload bytes are streamed out as kind 1
// with frame_last on the final one, a zero length reports kind 2, a disabled
// type reports kind 3, and more than MAX_LEN_GROUPS length groups report
// kind 4; the last two return the parser to idle. Throughput is one byte per
// clock: each byte is handled by one pass of the parser logic into a single
// result register, and the input stays ready while that register is empty or
// being emptied, so a result is valid in the cycle after its input transfer.
// The mask register sits at byte address 0 of the apb-style port and should
// only be written while no frame is in progress.

module varlen_frame_deframer_core #(
   parameter int unsigned MAX_LEN_GROUPS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   vfd_req_if.sink                             req_bus,
   vfd_rsp_if.source                           rsp_bus,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [vfd_pkg::CsrAddrWidth-1:0]    paddr,
   input  logic [vfd_pkg::CsrDataWidth-1:0]    pwdata,
   output logic [vfd_pkg::CsrDataWidth-1:0]    prdata,
   output logic                                pready
);

   logic [vfd_pkg::MaskWidth-1:0] type_mask;
   logic                          can_load;
   logic                          take;
   vfd_pkg::result_type           parse_result;
   vfd_pkg::result_type           held_result;

   // configuration registers
   vfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .type_mask (type_mask)
   );

   // input transfer happens whenever the result register can take a new entry
   assign req_bus.ready = can_load;
   assign take          = req_bus.valid && can_load;

   // frame parser: state registers plus next-state logic for one byte
   vfd_parser #(
      .MAX_LEN_GROUPS (MAX_LEN_GROUPS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .rx_byte   (req_bus.rx_byte),
      .chunk_end (req_bus.chunk_end),
      .type_mask (type_mask),
      .result    (parse_result)
   );

   // result register toward the sink
   vfd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (take),
      .result_in  (parse_result),
      .sink_ready (rsp_bus.ready),
      .out_valid  (rsp_bus.valid),
      .can_load   (can_load),
      .result_out (held_result)
   );

   // unpack the held result onto the channel fields
   assign rsp_bus.kind         = held_result.kind;
   assign rsp_bus.msg_type     = held_result.msg_type;
   assign rsp_bus.data_byte    = held_result.data_byte;
   assign rsp_bus.frame_last   = held_result.frame_last;
   assign rsp_bus.frame_length = held_result.frame_length;
   assign rsp_bus.chunk_done   = held_result.chunk_done;

endmodule
